// ----- rtl/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int ByteW  = 8;
  localparam int CodeW  = 22;
  localparam int LenW   = 4;
  localparam int TailW  = 18;
  localparam int TdataW = 32;   // code_point + bytes_used padded to bytes

  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1f;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0f;
  localparam logic [ByteW-1:0] SixMask   = 8'h3f;
  localparam logic [LenW-1:0]  LenMax    = 4'd15;
  localparam logic [LenW-1:0]  TailRuns  = 4'd4;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic [LenW-1:0]  bytes_used;
    logic             last;
  } result_t;

endpackage

// ----- rtl/utf8d_run.sv -----
// ----------------------------------------------------------------------------
// utf8d_run
// Run tracker: holds the open byte run and decodes it when it closes.
// ----------------------------------------------------------------------------
module utf8d_run (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_fire,
  input  logic [7:0]                 in_byte,
  output logic                       res_valid,
  output utf8d_pkg::result_t         res
);
  import utf8d_pkg::*;

  logic             pending;
  logic [ByteW-1:0] lead_byte;
  logic [TailW-1:0] tail_bits;
  logic [LenW-1:0]  run_length;

  logic             is_zero;
  logic             is_cont;
  logic [CodeW-1:0] decoded;

  assign is_zero = (in_byte == '0);
  assign is_cont = pending && ((in_byte & ContMask) == ContTag);

  // length follows the byte count, not the lead byte pattern
  always_comb begin
    case (run_length)
      4'd0, 4'd1: decoded = {{(CodeW-ByteW){1'b0}}, lead_byte};
      4'd2:       decoded = {11'b0, lead_byte[4:0], tail_bits[5:0]};
      4'd3:       decoded = {6'b0, lead_byte[3:0], tail_bits[11:0]};
      default:    decoded = {lead_byte[3:0], tail_bits};
    endcase
  end

  assign res_valid      = in_fire && pending && !is_cont;
  assign res.code_point = decoded;
  assign res.bytes_used = run_length;
  assign res.last       = is_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      lead_byte  <= '0;
      tail_bits  <= '0;
      run_length <= '0;
    end else if (in_fire) begin
      if (is_zero) begin
        pending    <= 1'b0;
        lead_byte  <= '0;
        tail_bits  <= '0;
        run_length <= '0;
      end else if (is_cont) begin
        // only the first three continuation bytes carry bits
        if (run_length < TailRuns) begin
          tail_bits <= {tail_bits[TailW-7:0], in_byte[5:0]};
        end
        if (run_length < LenMax) begin
          run_length <= run_length + 4'd1;
        end
      end else begin
        pending    <= 1'b1;
        lead_byte  <= in_byte;
        tail_bits  <= '0;
        run_length <= 4'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_zero) |=> (!pending && run_length == '0))
    else $error("zero byte did not close the run");

  assert property (@(posedge clk) disable iff (rst)
    pending |-> (run_length != '0))
    else $error("open run with zero length");

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_zero && !is_cont) |=> (pending && run_length == 4'd1))
    else $error("opening byte did not start a new run");

endmodule

// ----- rtl/utf8d_skid.sv -----
// ----------------------------------------------------------------------------
// utf8d_skid
// Output register with one skid entry, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module utf8d_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  utf8d_pkg::result_t   in_res,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8d_pkg::result_t   out_res
);
  import utf8d_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    load_main;

  assign in_ready  = !skid_valid;
  assign load_main = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_valid) begin
        out_res <= in_res;
      end
    end else if (in_valid) begin
      skid_res <= in_res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !skid_valid && in_valid) |=> skid_valid)
    else $error("result dropped while output stalled");

  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output");

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 style decoder: bytes in, one code point per byte run out.
//
// Input channel s_*: one byte per item. A nonzero byte not of the form 10xxxxxx
// (or any nonzero byte when no run is open) starts a run; continuation bytes extend
// it. A zero byte ends the string: the open run is flushed with m_tlast set.
// Output channel m_*: one item per finished run, carrying the code point and
// the run's byte count (saturating at 15).
// Throughput: one byte per cycle while s_tready is high. A result is loaded into the
// output register, or into the skid entry if that is stalled, as its closing byte is taken.
// The run state is a handful of registers updated in the accepting cycle;
// decoding is a mux on the run length feeding the output register.
// When the receiver stalls, one more result fits in a skid entry; s_tready
// then drops until the output register drains.
// Reset (rst, synchronous): no run open, output empty, s_tready high.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [21:0] code_point, [25:22] bytes_used, rest 0
  output logic        m_tlast    // last
);
  import utf8d_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_fire = s_tvalid && s_tready;

  utf8d_run u_run (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8d_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {{(TdataW-CodeW-LenW){1'b0}}, out_res.bytes_used, out_res.code_point};
  assign m_tlast = out_res.last;

endmodule

// ----- dv/utf8_run_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_run_checker
// Watches both streams of the UTF-8 stream decoder. Each byte taken on the
// input stream is run through a cycle-free model of the run state. Every
// code point that the model closes is queued and compared, field by field,
// with the next item leaving the output stream.
// ----------------------------------------------------------------------------
module utf8_run_checker
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [ByteW-1:0]  s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [TdataW-1:0] m_tdata,
  input  logic              m_tlast,
  output int                fail_count,
  output int                outstanding,
  output int                runs_checked,
  output int                runs_terminated
);
  timeunit 1ns;
  timeprecision 1ps;

  // model of the open run
  logic             run_open;
  logic [ByteW-1:0] run_lead;
  logic [TailW-1:0] run_tail;
  logic [LenW-1:0]  run_len;

  result_t code_points_due[$];

  function automatic logic [CodeW-1:0] run_code_point();
    logic [CodeW-1:0] lead;
    lead = CodeW'(run_lead);
    if (run_len <= 4'd1) return lead;
    if (run_len == 4'd2) return ((lead & CodeW'(Lead2Mask)) << 6) | CodeW'(run_tail[5:0]);
    if (run_len == 4'd3) return ((lead & CodeW'(Lead3Mask)) << 12) | CodeW'(run_tail[11:0]);
    return ((lead & CodeW'(Lead3Mask)) << 18) | CodeW'(run_tail);
  endfunction

  function automatic void close_run(input logic by_terminator);
    result_t r;
    r.code_point = run_code_point();
    r.bytes_used = run_len;
    r.last       = by_terminator;
    code_points_due.push_back(r);
  endfunction

  function automatic void clear_run();
    run_open = 1'b0;
    run_lead = '0;
    run_tail = '0;
    run_len  = '0;
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b);
    if (b == '0) begin
      if (run_open) close_run(1'b1);
      clear_run();
    end else if (run_open && (b & ContMask) == ContTag) begin
      // only the first three continuation bytes carry bits
      if (run_len < TailRuns) run_tail = {run_tail[TailW-7:0], b[5:0]};
      if (run_len < LenMax) run_len = run_len + 4'd1;
    end else begin
      if (run_open) close_run(1'b0);
      run_open = 1'b1;
      run_lead = b;
      run_tail = '0;
      run_len  = 4'd1;
    end
  endfunction

  function automatic void check_item();
    result_t          want;
    logic [CodeW-1:0] got_cp;
    logic [LenW-1:0]  got_len;
    logic [TdataW-CodeW-LenW-1:0] got_pad;
    got_cp  = m_tdata[CodeW-1:0];
    got_len = m_tdata[CodeW+LenW-1:CodeW];
    got_pad = m_tdata[TdataW-1:CodeW+LenW];
    if (code_points_due.size() == 0) begin
      $error("unexpected item: code_point %0h bytes_used %0d last %0b",
             got_cp, got_len, m_tlast);
      fail_count++;
      return;
    end
    want = code_points_due.pop_front();
    runs_checked++;
    if (want.last) runs_terminated++;
    if (got_cp !== want.code_point) begin
      $error("code_point: expected %0h, got %0h", want.code_point, got_cp);
      fail_count++;
    end
    if (got_len !== want.bytes_used) begin
      $error("bytes_used: expected %0d, got %0d", want.bytes_used, got_len);
      fail_count++;
    end
    if (m_tlast !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, m_tlast);
      fail_count++;
    end
    if (got_pad !== '0) begin
      $error("tdata padding: expected 0, got %0h", got_pad);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count      = 0;
    runs_checked    = 0;
    runs_terminated = 0;
    clear_run();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_run();
      code_points_due.delete();
    end else begin
      // a byte taken now cannot close a run leaving on the same edge
      if (m_tvalid && m_tready) check_item();
      if (s_tvalid && s_tready) decode_byte(s_tdata);
    end
    outstanding = code_points_due.size();
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives byte strings into the UTF-8 stream decoder: a short directed set of
// edge cases, then random strings of mostly well-formed runs with noise
// mixed in. Both stream sides idle at random; utf8_run_checker does the
// scoring.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8d_pkg::*;

  localparam int ByteTarget = 1300;
  localparam int StallLimit = 500;
  localparam int DrainWait  = 10;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [ByteW-1:0]  s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [TdataW-1:0] m_tdata;
  logic              m_tlast;

  int fail_count, outstanding, runs_checked, runs_terminated;
  int bytes_sent, strings_sent, stall_cycles;
  bit sender_idles, receiver_idles;

  always #5 clk = ~clk;

  utf8_stream_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  utf8_run_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .runs_checked    (runs_checked),
    .runs_terminated (runs_terminated)
  );

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = sender_idles ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (b == '0) strings_sent++;
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // opening byte shaped for a run of the given length
  function automatic logic [ByteW-1:0] lead_byte_for(input int len);
    case (len)
      1:       return 8'($urandom_range(1, 127));
      2:       return 8'hc0 | 8'($urandom_range(0, 31));
      3:       return 8'he0 | 8'($urandom_range(0, 15));
      default: return 8'hf0 | 8'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_run();
    int len, roll;
    logic [ByteW-1:0] lead;
    len  = $urandom_range(1, 4);
    lead = lead_byte_for(len);
    roll = $urandom_range(0, 99);
    if (roll < 6) len = $urandom_range(14, 20);       // length near or past saturation
    else if (roll < 20) len = $urandom_range(1, 6);   // length may disagree with lead
    send_byte(lead);
    repeat (len - 1) send_byte(cont_byte());
  endtask

  task automatic send_string();
    int runs;
    runs = $urandom_range(1, 8);
    repeat (runs) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));  // noise
      else send_run();
    end
    if ($urandom_range(0, 99) < 85) send_byte('0);
  endtask

  initial begin
    logic [ByteW-1:0] directed[$];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    bytes_sent   = 0;
    strings_sent = 0;
    sender_idles = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // terminator with nothing open; stray continuation as lead; 1..3 byte
    // runs; an overlong run that swallows tail bits and saturates its count
    directed = '{8'h00, 8'h80, 8'hbf, 8'h41, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hff};
    foreach (directed[i]) send_byte(directed[i]);
    for (int i = 0; i < 15; i++) send_byte(i[0] ? 8'hbf : 8'h80);
    send_byte(8'h00);

    while (bytes_sent < ByteTarget) begin
      sender_idles = $urandom_range(0, 3) != 0;
      send_string();
    end
    send_byte(8'h00);
    s_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (DrainWait) @(posedge clk);
    $display("Sent %0d bytes in %0d terminated strings.", bytes_sent, strings_sent);
    $display("Checked %0d code points, %0d closed by a terminator.",
             runs_checked, runs_terminated);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random stall before each item, with stall-free stretches
  initial begin
    int gap, taken;
    m_tready = 1'b0;
    taken = 0;
    receiver_idles = 1'b1;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) receiver_idles = $urandom_range(0, 3) != 0;
      gap = receiver_idles ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Timeout: no item moved for %0d cycles.", StallLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial stall_cycles = 0;

endmodule

// ----- filelist.f -----
rtl/utf8d_pkg.sv
rtl/utf8d_run.sv
rtl/utf8d_skid.sv
rtl/utf8_stream_decoder.sv
dv/utf8_run_checker.sv
dv/tb.sv
